### rtl/core/sil_pkg.sv
// Package: shared constants and controller/datapath interface types for the sorted insert list.
`default_nettype none
package sil_pkg;

    localparam int DEPTH = 16;
    localparam int VAL_W = 32;
    localparam int POS_W = 4;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the input value, set reject flag, update count
        logic rd_scan;   // read the store at the scan index
        logic rd_out;    // read the store at the readout index
        logic wr_shift;  // move the entry just read one place up
        logic wr_above;  // write the new value just above the scan index
        logic wr_zero;   // write the new value at the bottom of the store
        logic scan_dec;  // step the scan index down
        logic out_load;  // load the output register from the read data
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;       // store holds DEPTH entries
        logic empty;      // store holds nothing
        logic ge;         // entry just read is greater than or equal to the new value
        logic scan_zero;  // scan index has reached the bottom entry
        logic out_taken;  // output transaction completes this cycle
        logic out_last;   // output register holds the final entry of the readout
    } t_status;

endpackage
`default_nettype wire

### rtl/core/sil_dp.sv
// Datapath: value store, scan and readout indexes, entry count and output register.
`default_nettype none
module sil_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire sil_pkg::t_cmd                       i_cmd,
    output sil_pkg::t_status                         o_sts,
    input  wire logic signed [sil_pkg::VAL_W-1:0]    i_value,
    input  wire logic                                i_stall,
    output logic                                     o_valid,
    output logic signed [sil_pkg::VAL_W-1:0]         o_entry_value,
    output logic        [sil_pkg::POS_W-1:0]         o_position,
    output logic                                     o_last,
    output logic                                     o_rejected
);

    logic signed [sil_pkg::VAL_W-1:0] r_mem [sil_pkg::DEPTH];

    logic signed [sil_pkg::VAL_W-1:0] r_value;
    logic signed [sil_pkg::VAL_W-1:0] r_rdata;
    logic                             r_reject;
    logic [sil_pkg::CNT_W-1:0]        r_count;
    logic [sil_pkg::IDX_W-1:0]        r_scan_idx;
    logic [sil_pkg::IDX_W-1:0]        r_out_idx;

    logic                             r_out_valid;
    logic signed [sil_pkg::VAL_W-1:0] r_out_value;
    logic [sil_pkg::IDX_W-1:0]        r_out_pos;
    logic                             r_out_last;
    logic                             r_out_rej;

    logic [sil_pkg::CNT_W-1:0]        cnt_m1;
    logic                             full;
    logic                             wr_en;
    logic [sil_pkg::IDX_W-1:0]        wr_addr;
    logic signed [sil_pkg::VAL_W-1:0] wr_data;
    logic                             rd_en;
    logic [sil_pkg::IDX_W-1:0]        rd_addr;

    assign cnt_m1 = r_count - sil_pkg::CNT_W'(1);
    assign full   = (r_count == sil_pkg::CNT_W'(sil_pkg::DEPTH));

    always_comb begin
        wr_en   = i_cmd.wr_shift | i_cmd.wr_above | i_cmd.wr_zero;
        wr_addr = i_cmd.wr_zero ? '0 : (r_scan_idx + sil_pkg::IDX_W'(1));
        wr_data = i_cmd.wr_shift ? r_rdata : r_value;
        rd_en   = i_cmd.rd_scan | i_cmd.rd_out;
        rd_addr = i_cmd.rd_scan ? r_scan_idx : r_out_idx;
    end

    // Single write port and single registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value    <= i_value;
            r_reject   <= full;
            r_scan_idx <= cnt_m1[sil_pkg::IDX_W-1:0];
        end else if (i_cmd.scan_dec) begin
            r_scan_idx <= r_scan_idx - sil_pkg::IDX_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_rdata;
            r_out_pos   <= r_out_idx;
            r_out_last  <= ({1'b0, r_out_idx} == cnt_m1);
            r_out_rej   <= r_reject;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_out_idx <= '0;
                if (!full) begin
                    r_count <= r_count + sil_pkg::CNT_W'(1);
                end
            end else if (i_cmd.out_load) begin
                r_out_idx <= r_out_idx + sil_pkg::IDX_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.full      = full;
        o_sts.empty     = (r_count == '0);
        o_sts.ge        = (r_rdata >= r_value);
        o_sts.scan_zero = (r_scan_idx == '0);
        o_sts.out_taken = r_out_valid & ~i_stall;
        o_sts.out_last  = r_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_entry_value = r_out_value;
    assign o_position    = sil_pkg::POS_W'(r_out_pos);
    assign o_last        = r_out_last;
    assign o_rejected    = r_out_rej;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sil_pkg::CNT_W'(sil_pkg::DEPTH))
        else $error("entry count exceeds store depth");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("output register loaded while still occupied");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> ({1'b0, r_out_pos} == cnt_m1))
        else $error("final entry of readout is not the top of the store");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rej) |-> full)
        else $error("rejected readout while store not full");
`endif

endmodule
`default_nettype wire

### rtl/core/sil_ctrl.sv
// Controller: state machine sequencing the insert scan and the readout.
`default_nettype none
module sil_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire sil_pkg::t_status i_sts,
    output sil_pkg::t_cmd         o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PUT0  = 7'b0000010,
        S_SRD   = 7'b0000100,
        S_SCMP  = 7'b0001000,
        S_OREQ  = 7'b0010000,
        S_OLOAD = 7'b0100000,
        S_OWAIT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.full) begin
                        n_state = S_OREQ;
                    end else if (i_sts.empty) begin
                        n_state = S_PUT0;
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end
            S_PUT0: begin
                o_cmd.wr_zero = 1'b1;
                n_state       = S_OREQ;
            end
            S_SRD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SCMP;
            end
            S_SCMP: begin
                if (i_sts.ge) begin
                    o_cmd.wr_shift = 1'b1;
                    if (i_sts.scan_zero) begin
                        n_state = S_PUT0;
                    end else begin
                        o_cmd.scan_dec = 1'b1;
                        n_state        = S_SRD;
                    end
                end else begin
                    o_cmd.wr_above = 1'b1;
                    n_state        = S_OREQ;
                end
            end
            S_OREQ: begin
                o_cmd.rd_out = 1'b1;
                n_state      = S_OLOAD;
            end
            S_OLOAD: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OWAIT;
            end
            S_OWAIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_out = 1'b1;
                        n_state      = S_OLOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

### rtl/core/sorted_insert_list_top.sv
// Top level: bounded ascending store of signed values with a full readout after each insert.
`default_nettype none
// The block keeps up to 16 signed 32-bit values in ascending order. Each input
// transaction inserts its value just ahead of the first stored value that is
// greater than or equal to it, so equal values sit newest first. After every
// insert the whole ordered contents are read out, smallest first, one output
// transaction per stored entry, with o_last on the final one. When the store is
// already full the value is dropped, the contents are unchanged, and every
// output transaction of that readout carries o_rejected. The block works on one
// input transaction at a time and holds o_stall high until the readout is fully
// delivered. The insert walks down from the top of the store through its single
// read port and single write port, moving up each entry that is greater than or
// equal to the new value, then places the new value at the bottom when every
// entry has moved, or else just above the first entry that is less than it. The
// readout then fetches the entries in turn into the output register, fetching
// each next one only once the output side has taken the one before. No clearing
// pass is needed after reset: entries above the fill count are never read.
module sorted_insert_list_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [sil_pkg::VAL_W-1:0]    i_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [sil_pkg::VAL_W-1:0]         o_entry_value,
    output logic        [sil_pkg::POS_W-1:0]         o_position,
    output logic                                     o_last,
    output logic                                     o_rejected
);

    // Command and status links between the sequencer and the datapath.
    sil_pkg::t_cmd    cmd;
    sil_pkg::t_status sts;

    // The controller accepts an input transaction only when idle and then
    // steps through the scan and readout.
    sil_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath holds the store, the fill count and the output register.
    sil_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_value       (i_value),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_entry_value (o_entry_value),
        .o_position    (o_position),
        .o_last        (o_last),
        .o_rejected    (o_rejected)
    );

endmodule
`default_nettype wire

### sim/sorted_insert_list_top_tb.sv
// Self-checking testbench for the sorted insert list: directed table, random inserts, checker.
`timescale 1ns / 1ps

module sorted_insert_list_top_tb;

    localparam int DEPTH = sil_pkg::DEPTH;
    localparam int VAL_W = sil_pkg::VAL_W;
    localparam int POS_W = sil_pkg::POS_W;

    localparam int HALF_PERIOD_NS = 2;
    localparam int RESET_CYCLES   = 3;
    // Waiting well past the longest insert after the last owed entry lets any stray
    // entry show up.
    localparam int DRAIN_CYCLES   = 150;
    localparam int HOLD_CYCLES    = 300;
    // The timeout lies well beyond the slowest correct run.
    localparam int TIMEOUT_NS     = 4_000_000;

    localparam int RANDOM_ITEMS_PER_PHASE = 157;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // One entry of a readout, as it appears on the output side.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
        logic                    last;
        logic                    rejected;
    } t_entry;

    // A row of the directed table. Where typed_count is zero the expected readout
    // comes from the predictor; otherwise the typed entries are the whole readout.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [1:0]              typed_count;
        t_entry                  typed0;
        t_entry                  typed1;
    } t_directed_row;

    localparam int N_DIRECTED = 19;

    // Fills the store from empty, hitting both extremes, all-ones, alternating bit
    // patterns, duplicates at the bottom, middle and top, then offers three values
    // to the full store so that each of them is dropped.
    localparam t_directed_row DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        '{32'sd0,          2'd1, '{32'sd0,          4'd0, 1'b1, 1'b0}, '0},
        '{32'sh8000_0000,  2'd2, '{32'sh8000_0000,  4'd0, 1'b0, 1'b0},
                                 '{32'sd0,          4'd1, 1'b1, 1'b0}},
        '{32'sh7FFF_FFFF,  2'd0, '0, '0},
        '{-32'sd1,         2'd0, '0, '0},
        '{32'sd1,          2'd0, '0, '0},
        '{32'sd0,          2'd0, '0, '0},
        '{32'sh8000_0000,  2'd0, '0, '0},
        '{32'sh7FFF_FFFF,  2'd0, '0, '0},
        '{32'sh5555_5555,  2'd0, '0, '0},
        '{32'shAAAA_AAAA,  2'd0, '0, '0},
        '{-32'sd1,         2'd0, '0, '0},
        '{32'sd100,        2'd0, '0, '0},
        '{-32'sd100,       2'd0, '0, '0},
        '{32'sh7FFF_FFFE,  2'd0, '0, '0},
        '{32'sh8000_0001,  2'd0, '0, '0},
        '{32'sd42,         2'd0, '0, '0},
        '{32'sh8000_0000,  2'd0, '0, '0},
        '{32'sh7FFF_FFFF,  2'd0, '0, '0},
        '{32'sd7,          2'd0, '0, '0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [VAL_W-1:0] o_entry_value;
    logic [POS_W-1:0]        o_position;
    logic                    o_last;
    logic                    o_rejected;

    sorted_insert_list_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_entry_value (o_entry_value),
        .o_position    (o_position),
        .o_last        (o_last),
        .o_rejected    (o_rejected)
    );

    always #(HALF_PERIOD_NS) i_clk = ~i_clk;

    // Our own copy of the ordered store, kept in step with every accepted insert.
    logic signed [VAL_W-1:0] shadow_store [DEPTH];
    int                      shadow_count = 0;

    // Readout entries still owed by the block, oldest first.
    t_entry readout_q [$];

    int mismatches       = 0;
    int entries_checked  = 0;
    int rejected_entries = 0;
    int inserts_done     = 0;
    int input_held_off   = 0;

    // Idling percentages for each side and the remaining length of a forced hold-off.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Inserts a value into the shadow store exactly as the block should, and when
    // asked queues the readout that must follow. A full store drops the value and
    // every entry of its readout is flagged as rejected.
    function automatic void model_insert(input logic signed [VAL_W-1:0] v, input bit queue_it);
        int     slot;
        int     i;
        bit     dropped;
        t_entry e;
        dropped = (shadow_count >= DEPTH);
        if (!dropped) begin
            slot = 0;
            while (slot < shadow_count && shadow_store[slot] < v)
                slot++;
            for (i = shadow_count; i > slot; i--)
                shadow_store[i] = shadow_store[i-1];
            shadow_store[slot] = v;
            shadow_count++;
        end
        if (queue_it) begin
            for (i = 0; i < shadow_count; i++) begin
                e.value    = shadow_store[i];
                e.position = i[POS_W-1:0];
                e.last     = (i == shadow_count - 1);
                e.rejected = dropped;
                readout_q.push_back(e);
            end
        end
    endfunction

    // Offers one value, with random idle cycles ahead of it, and waits for the
    // input transaction to complete. The shadow store is updated on acceptance.
    task automatic insert_value(input logic signed [VAL_W-1:0] v, input bit queue_it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        model_insert(v, queue_it);
        inserts_done++;
    endtask

    // Random values: mostly full-range, with a share of extremes, small values
    // and exact copies of stored entries, so ties against the contents also occur.
    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            6: begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
            7: v = (shadow_count > 0) ? shadow_store[$urandom_range(0, shadow_count - 1)]
                                      : $urandom;
            8: v = $signed($urandom_range(0, 16)) - 8;
            9: v = $urandom_range(0, 1) ? VAL_MIN + $urandom_range(0, 3)
                                        : VAL_MAX - $urandom_range(0, 3);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic run_random_inserts(input int count);
        int n;
        for (n = 0; n < count; n++)
            insert_value(pick_value(), 1'b1);
    endtask

    // Output side: stalls at random, or throughout a forced hold-off. The hold-off
    // is counted down here so that its length does not depend on the sender.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Checker: every completed output transaction is compared with the oldest
    // owed readout entry, field by field.
    always @(posedge i_clk) begin : readout_check
        t_entry want;
        if (i_rst_n && i_valid && o_stall)
            input_held_off++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (readout_q.size() == 0) begin
                report_mismatch($sformatf("unexpected entry value %0d position %0d",
                                          o_entry_value, o_position));
            end else begin
                want = readout_q.pop_front();
                entries_checked++;
                if (o_rejected === 1'b1)
                    rejected_entries++;
                if (o_entry_value !== want.value)
                    report_mismatch($sformatf("entry_value %0d, wanted %0d at position %0d",
                                              o_entry_value, want.value, want.position));
                if (o_position !== want.position)
                    report_mismatch($sformatf("position %0d, wanted %0d",
                                              o_position, want.position));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %b, wanted %b at position %0d",
                                              o_last, want.last, want.position));
                if (o_rejected !== want.rejected)
                    report_mismatch($sformatf("rejected %b, wanted %b at position %0d",
                                              o_rejected, want.rejected, want.position));
            end
        end
    end

    initial begin : stimulus
        int r;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        send_idle_pct = 21;
        recv_idle_pct = 76;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. The first two rows carry their readouts typed in; every
        // other row is checked against the shadow store.
        for (r = 0; r < N_DIRECTED; r++) begin
            insert_value(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed_count == 0);
            if (DIRECTED_ROWS[r].typed_count >= 1)
                readout_q.push_back(DIRECTED_ROWS[r].typed0);
            if (DIRECTED_ROWS[r].typed_count >= 2)
                readout_q.push_back(DIRECTED_ROWS[r].typed1);
        end

        // Random inserts. The store is full by now, so each of these is dropped
        // and answered with a complete readout of sixteen rejected entries.
        run_random_inserts(RANDOM_ITEMS_PER_PHASE);

        send_idle_pct = 76;
        recv_idle_pct = 21;
        run_random_inserts(RANDOM_ITEMS_PER_PHASE);

        // No idling on either side, opened by a long hold-off on the output side
        // while the sender keeps offering, so that the block backs up onto its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        run_random_inserts(RANDOM_ITEMS_PER_PHASE);
        i_valid <= 1'b0;

        while (readout_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts (%0d from the table) and checked %0d readout entries,",
                 inserts_done, N_DIRECTED, entries_checked);
        $display("%0d of them rejected; the input was held off for %0d cycles under back-pressure.",
                 rejected_entries, input_held_off);
        if (mismatches == 0) begin
            $display("PASS sorted_insert_list_top");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL sorted_insert_list_top");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timed out with %0d readout entries outstanding", readout_q.size());
        $display("FAIL sorted_insert_list_top");
        $finish;
    end

endmodule

### filelist.f
rtl/core/sil_pkg.sv
rtl/core/sil_dp.sv
rtl/core/sil_ctrl.sv
rtl/core/sorted_insert_list_top.sv
sim/sorted_insert_list_top_tb.sv
